FILE: rtl/fscos_pkg.sv
`timescale 1ns / 1ps

package fscos_pkg;

  localparam int ANGLE_FRAC_BITS = 24;
  localparam int OUT_FRAC_BITS   = 16;

  localparam int ANGLE_W = 32;
  localparam int OUT_W   = OUT_FRAC_BITS + 2;
  localparam int A_W     = ANGLE_W + 1;

  // pi in Q60, rounded to the angle format below
  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;
  localparam logic [63:0] K_PI =
    (PI_Q60 + (64'd1 << (59 - ANGLE_FRAC_BITS))) >> (60 - ANGLE_FRAC_BITS);
  localparam logic [63:0] K_HALF_PI =
    (PI_Q60 + (64'd1 << (60 - ANGLE_FRAC_BITS))) >> (61 - ANGLE_FRAC_BITS);
  localparam logic [63:0] K_TWO_PI =
    (PI_Q60 + (64'd1 << (58 - ANGLE_FRAC_BITS))) >> (59 - ANGLE_FRAC_BITS);
  localparam logic [63:0] K_THREE_HALF_PI = K_PI + K_HALF_PI;

  // raw remainder (signed, in [-2pi, 4pi)), wrapped angle and folded angle widths
  localparam int RW  = ANGLE_FRAC_BITS + 5;
  localparam int RRW = ANGLE_FRAC_BITS + 3;
  localparam int XW  = ANGLE_FRAC_BITS + 1;

  // reciprocal of 2pi for the quotient estimate
  localparam int QS = 32 + ANGLE_FRAC_BITS;
  localparam int MW = 31;
  localparam int PW = A_W + MW + 1;
  localparam logic [MW-1:0] RECIP_TWO_PI = MW'((64'd1 << QS) / K_TWO_PI);

  localparam logic [A_W-1:0] K_HALF_PI_A  = A_W'(K_HALF_PI);
  localparam logic [RW-1:0]  K_TWO_PI_RW  = RW'(K_TWO_PI);
  localparam logic [RRW-1:0] K_HALF_PI_R  = RRW'(K_HALF_PI);
  localparam logic [RRW-1:0] K_PI_R       = RRW'(K_PI);
  localparam logic [RRW-1:0] K_THREE_HALF_PI_R = RRW'(K_THREE_HALF_PI);
  localparam logic [RRW-1:0] K_TWO_PI_R   = RRW'(K_TWO_PI);
  localparam logic [XW-1:0]  X_MAX        = XW'(K_PI - K_HALF_PI);

  // polynomial in Q30 / Q60
  localparam int X30_W = 31;
  localparam int SQ_W  = 32;
  localparam int ACC_W = 64;
  localparam logic signed [31:0] COEF_A2 = -32'sd621948235;
  localparam logic signed [31:0] COEF_A3 = 32'sd118905972;
  localparam int RND_SH = 60 - OUT_FRAC_BITS;
  localparam logic signed [ACC_W-1:0] ACC_BIAS =
    (64'sd1 <<< 60) + (64'sd1 <<< (RND_SH - 1));

  localparam int V_W = OUT_FRAC_BITS + 3;
  localparam logic signed [V_W-1:0]   ONE_V   = V_W'(64'd1 << OUT_FRAC_BITS);
  localparam logic signed [OUT_W-1:0] ONE_OUT = OUT_W'(64'd1 << OUT_FRAC_BITS);

  typedef struct packed {
    logic          neg;
    logic [XW-1:0] x;
  } fold_t;

endpackage

FILE: rtl/fscos_reduce.sv
`timescale 1ns / 1ps

module fscos_reduce (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    en_i,
  input  logic                                    valid_i,
  input  logic                                    opcode_i,
  input  logic signed [fscos_pkg::ANGLE_W-1:0]    angle_i,
  output logic                                    valid_o,
  output fscos_pkg::fold_t                        fold_o
);

  logic [5:0] vld_q;

  logic signed [fscos_pkg::A_W-1:0] a1_d, a1_q;
  logic signed [fscos_pkg::PW-1:0]  p2_d, p2_q;
  logic [fscos_pkg::RW-1:0]         a2_q, a3_q;
  logic [fscos_pkg::PW-fscos_pkg::QS-1:0] q3;
  logic [fscos_pkg::RW-1:0]         q3_ext, t3_d, t3_q;
  logic [fscos_pkg::RW-1:0]         r4_d, r4_q;
  logic [fscos_pkg::RRW-1:0]        r5_d, r5_q;
  fscos_pkg::fold_t                 fold_d, fold_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[4:0], valid_i};
    end
  end

  // stage 1: sine offset
  assign a1_d = fscos_pkg::A_W'(angle_i)
              - (opcode_i ? $signed(fscos_pkg::K_HALF_PI_A) : fscos_pkg::A_W'(0));

  // stage 2: quotient estimate via reciprocal of 2pi
  assign p2_d = fscos_pkg::PW'(a1_q)
              * fscos_pkg::PW'($signed({1'b0, fscos_pkg::RECIP_TWO_PI}));

  // stage 3: quotient times 2pi, only the low bits matter for the remainder
  assign q3     = p2_q[fscos_pkg::PW-1:fscos_pkg::QS];
  assign q3_ext = fscos_pkg::RW'($signed(q3));
  assign t3_d   = q3_ext * fscos_pkg::K_TWO_PI_RW;

  // stage 4: raw remainder, off by at most one period
  assign r4_d = a3_q - t3_q;

  // stage 5: correct into [0, 2pi)
  always_comb begin
    if (r4_q[fscos_pkg::RW-1]) begin
      r5_d = fscos_pkg::RRW'(r4_q + fscos_pkg::K_TWO_PI_RW);
    end else if (r4_q >= fscos_pkg::K_TWO_PI_RW) begin
      r5_d = fscos_pkg::RRW'(r4_q - fscos_pkg::K_TWO_PI_RW);
    end else begin
      r5_d = fscos_pkg::RRW'(r4_q);
    end
  end

  // stage 6: quadrant fold, quadrant edges belong to the next quadrant
  always_comb begin
    if (r5_q < fscos_pkg::K_HALF_PI_R) begin
      fold_d.x   = fscos_pkg::XW'(r5_q);
      fold_d.neg = 1'b0;
    end else if (r5_q < fscos_pkg::K_PI_R) begin
      fold_d.x   = fscos_pkg::XW'(fscos_pkg::K_PI_R - r5_q);
      fold_d.neg = 1'b1;
    end else if (r5_q < fscos_pkg::K_THREE_HALF_PI_R) begin
      fold_d.x   = fscos_pkg::XW'(r5_q - fscos_pkg::K_PI_R);
      fold_d.neg = 1'b1;
    end else begin
      fold_d.x   = fscos_pkg::XW'(fscos_pkg::K_TWO_PI_R - r5_q);
      fold_d.neg = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a1_q   <= a1_d;
      p2_q   <= p2_d;
      a2_q   <= a1_q[fscos_pkg::RW-1:0];
      t3_q   <= t3_d;
      a3_q   <= a2_q;
      r4_q   <= r4_d;
      r5_q   <= r5_d;
      fold_q <= fold_d;
    end
  end

  assign valid_o = vld_q[5];
  assign fold_o  = fold_q;

endmodule

FILE: rtl/fscos_poly.sv
`timescale 1ns / 1ps

module fscos_poly (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  en_i,
  input  logic                                  valid_i,
  input  fscos_pkg::fold_t                      fold_i,
  output logic                                  valid_o,
  output logic signed [fscos_pkg::OUT_W-1:0]    value_o
);

  logic [4:0] vld_q;
  logic [3:0] neg_q;

  logic [fscos_pkg::X30_W-1:0] x30;
  logic [fscos_pkg::X30_W-1:0] x7_q;
  logic [fscos_pkg::SQ_W-1:0]  sq7_d, sq7_q, sq8_q, cu8_d, cu8_q;
  logic signed [fscos_pkg::ACC_W-1:0] term2_d, term2_q, term3_d, term3_q;
  logic signed [fscos_pkg::ACC_W-1:0] acc_d, acc_q;
  logic signed [fscos_pkg::V_W-1:0]   v_rnd, v_sgn;
  logic signed [fscos_pkg::OUT_W-1:0] value_d, value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[3:0], valid_i};
    end
  end

  // stage 7: x^2 in Q30
  assign x30   = fscos_pkg::X30_W'(fold_i.x) << (30 - fscos_pkg::ANGLE_FRAC_BITS);
  assign sq7_d = fscos_pkg::SQ_W'((64'(x30) * 64'(x30)) >> 30);

  // stage 8: x^3 in Q30
  assign cu8_d = fscos_pkg::SQ_W'((64'(sq7_q) * 64'(x7_q)) >> 30);

  // stage 9: coefficient products in Q60
  assign term2_d = fscos_pkg::ACC_W'(fscos_pkg::COEF_A2)
                 * fscos_pkg::ACC_W'($signed({1'b0, sq8_q}));
  assign term3_d = fscos_pkg::ACC_W'(fscos_pkg::COEF_A3)
                 * fscos_pkg::ACC_W'($signed({1'b0, cu8_q}));

  // stage 10: sum with one and the rounding half
  assign acc_d = fscos_pkg::ACC_BIAS + term2_q + term3_q;

  // stage 11: scale, sign and clamp
  assign v_rnd = fscos_pkg::V_W'(acc_q >>> fscos_pkg::RND_SH);
  assign v_sgn = neg_q[3] ? -v_rnd : v_rnd;

  always_comb begin
    if (v_sgn > fscos_pkg::ONE_V) begin
      value_d = fscos_pkg::ONE_OUT;
    end else if (v_sgn < -fscos_pkg::ONE_V) begin
      value_d = -fscos_pkg::ONE_OUT;
    end else begin
      value_d = fscos_pkg::OUT_W'(v_sgn);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      neg_q   <= {neg_q[2:0], fold_i.neg};
      x7_q    <= x30;
      sq7_q   <= sq7_d;
      sq8_q   <= sq7_q;
      cu8_q   <= cu8_d;
      term2_q <= term2_d;
      term3_q <= term3_d;
      acc_q   <= acc_d;
      value_q <= value_d;
    end
  end

  assign valid_o = vld_q[4];
  assign value_o = value_q;

endmodule

FILE: rtl/fast_sine_cosine_approx_top.sv
`timescale 1ns / 1ps
// throughput: one transaction per cycle; the 11-stage pipeline advances as one
// and holds in place while a result on the output is not taken
// reset clears the stage valid bits only; data registers are not reset

module fast_sine_cosine_approx_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic                                  opcode_i,
  input  logic signed [fscos_pkg::ANGLE_W-1:0]  angle_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [fscos_pkg::OUT_W-1:0]    value_o
);

  logic             en;
  logic             red_valid;
  fscos_pkg::fold_t red_fold;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = en;

  fscos_reduce u_reduce (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .valid_i  (in_valid_i),
    .opcode_i (opcode_i),
    .angle_i  (angle_i),
    .valid_o  (red_valid),
    .fold_o   (red_fold)
  );

  fscos_poly u_poly (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (red_valid),
    .fold_i  (red_fold),
    .valid_o (out_valid_o),
    .value_o (value_o)
  );

  // folded angle never exceeds a quarter turn (plus the rounding step)
  a_fold_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    red_valid |-> (red_fold.x <= fscos_pkg::X_MAX))
    else $error("folded angle out of range");

  // result stays within plus or minus one
  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((value_o <= fscos_pkg::ONE_OUT) && (value_o >= -fscos_pkg::ONE_OUT)))
    else $error("result beyond unit range");

  // a held result keeps the whole pipeline frozen
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> ($stable(red_fold) && $stable(red_valid)))
    else $error("pipeline moved while output stalled");

endmodule

FILE: bench/fscos_tb_pkg.sv
`timescale 1ns / 1ps

package fscos_tb_pkg;

  typedef enum logic {
    OP_COS = 1'b0,
    OP_SIN = 1'b1
  } trig_op_e;

  localparam int FRAC = fscos_pkg::ANGLE_FRAC_BITS;

  // pi in Q60, rounded to nearest at the angle's fraction bits
  localparam logic [63:0] PI_Q60_REF = 64'h3243F6A8885A308D;
  localparam longint QTR_TURN =
    longint'((PI_Q60_REF + (64'd1 << (60 - FRAC))) >> (61 - FRAC));
  localparam longint HALF_TURN =
    longint'((PI_Q60_REF + (64'd1 << (59 - FRAC))) >> (60 - FRAC));
  localparam longint FULL_TURN =
    longint'((PI_Q60_REF + (64'd1 << (58 - FRAC))) >> (59 - FRAC));
  localparam longint THREE_QTR_TURN = HALF_TURN + QTR_TURN;

endpackage

FILE: bench/fscos_checker.sv
`timescale 1ns / 1ps

module fscos_checker
  import fscos_pkg::*;
  import fscos_tb_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_ready_i,
  input  logic                     opcode_i,
  input  logic signed [ANGLE_W-1:0] angle_i,
  input  logic                     out_valid_i,
  input  logic                     out_ready_i,
  input  logic signed [OUT_W-1:0]  value_i,
  output int                       fail_count_o,
  output int                       pending_o
);

  localparam longint COEF_SQ = -64'sd621948235;
  localparam longint COEF_CU = 64'sd118905972;
  localparam int     RSH     = 60 - OUT_FRAC_BITS;

  typedef struct {
    trig_op_e                 op;
    logic signed [ANGLE_W-1:0] ang;
    logic signed [OUT_W-1:0]  val;
  } trig_expect_t;

  trig_expect_t expected_values[$];
  trig_expect_t oldest;

  function automatic logic signed [OUT_W-1:0] trig_value(trig_op_e op,
                                                         logic signed [ANGLE_W-1:0] ang);
    longint a, r, x, acc, v, one;
    longint unsigned x30, sq, cu, biased;
    logic flip;
    flip = 1'b0;
    one  = longint'(1) <<< OUT_FRAC_BITS;
    a = longint'(ang);
    if (op == OP_SIN) a = a - QTR_TURN;
    // floor modulo into [0, 2pi)
    r = a % FULL_TURN;
    if (r < 0) r = r + FULL_TURN;
    if (r < QTR_TURN) begin
      x = r;
    end else if (r < HALF_TURN) begin
      x = HALF_TURN - r;
      flip = 1'b1;
    end else if (r < THREE_QTR_TURN) begin
      x = r - HALF_TURN;
      flip = 1'b1;
    end else begin
      x = FULL_TURN - r;
    end
    if (x < 0) x = 0;
    x30 = $unsigned(x) << (30 - FRAC);
    sq  = (x30 * x30) >> 30;
    cu  = (sq * x30) >> 30;
    acc = (longint'(1) <<< 60) + COEF_SQ * $signed(sq) + COEF_CU * $signed(cu);
    // offset keeps the shift on a non-negative value, so rounding is half up
    biased = $unsigned(acc + (longint'(1) <<< 61)) + (64'd1 << (RSH - 1));
    v = $signed(biased >> RSH) - (longint'(1) <<< (61 - RSH));
    if (flip) v = -v;
    if (v > one) v = one;
    if (v < -one) v = -one;
    return OUT_W'(v);
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    fail_count_o = fail_count_o + 1;
  endtask

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        expected_values.push_back('{op: trig_op_e'(opcode_i), ang: angle_i,
                                    val: trig_value(trig_op_e'(opcode_i), angle_i)});
      end
      if (out_valid_i && out_ready_i) begin
        if (expected_values.size() == 0) begin
          report_mismatch($sformatf("value %0d with no transaction outstanding", value_i));
        end else begin
          oldest = expected_values.pop_front();
          if (value_i !== oldest.val) begin
            report_mismatch($sformatf("%s angle 0x%08h: value %0d, predicted %0d",
                                      oldest.op.name(), oldest.ang, value_i, oldest.val));
          end
        end
      end
      pending_o = expected_values.size();
    end
  end

endmodule

FILE: bench/tb_fast_sine_cosine_approx_top.sv
`timescale 1ns / 1ps

module tb_fast_sine_cosine_approx_top;
  import fscos_pkg::*;
  import fscos_tb_pkg::*;

  localparam int RAND_ITEMS  = 2000;
  localparam int HOLD_CYCLES = 200;

  logic                      clk_i;
  logic                      rst_ni;
  logic                      in_valid_i;
  logic                      in_ready_o;
  logic                      opcode_i;
  logic signed [ANGLE_W-1:0] angle_i;
  logic                      out_valid_o;
  logic                      out_ready_i;
  logic signed [OUT_W-1:0]   value_o;

  int fail_count;
  int pending;
  bit idle_on;
  bit hold_req;

  logic signed [ANGLE_W-1:0] corner_angles [12];

  fast_sine_cosine_approx_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .opcode_i   (opcode_i),
    .angle_i    (angle_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .value_o    (value_o)
  );

  fscos_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .opcode_i    (opcode_i),
    .angle_i     (angle_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .value_i     (value_o),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // four in ten near quadrant boundaries, where the fold and the sign flip matter
  function automatic logic signed [ANGLE_W-1:0] next_random_angle();
    longint t;
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 4) return $urandom();
    if (pick < 8) begin
      t = longint'($urandom_range(0, 162)) - 81;
      t = t * QTR_TURN + longint'($urandom_range(0, 16)) - 8;
      if (t >= -64'sd2147483648 && t <= 64'sd2147483647) return ANGLE_W'(t);
      return $urandom();
    end
    t = longint'($urandom_range(0, 32'(2 * FULL_TURN))) - FULL_TURN;
    return ANGLE_W'(t);
  endfunction

  task automatic send_item(trig_op_e op, logic signed [ANGLE_W-1:0] ang);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i   <= op;
    angle_i    <= ang;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  initial begin
    corner_angles = '{32'sd0, -32'sd1, 32'sh7FFFFFFF, 32'sh80000000,
                      ANGLE_W'(QTR_TURN), ANGLE_W'(QTR_TURN - 1),
                      ANGLE_W'(HALF_TURN), ANGLE_W'(HALF_TURN - 1),
                      ANGLE_W'(THREE_QTR_TURN), ANGLE_W'(THREE_QTR_TURN - 1),
                      ANGLE_W'(FULL_TURN - 1), ANGLE_W'(-QTR_TURN)};
    idle_on  = 1'b1;
    hold_req = 1'b0;
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    opcode_i   <= OP_COS;
    angle_i    <= '0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (corner_angles[i]) begin
      send_item(OP_COS, corner_angles[i]);
      send_item(OP_SIN, corner_angles[i]);
    end

    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 100 == 0) begin
        // quiet stretches now and then, and none at all near the end
        idle_on = (n < RAND_ITEMS - 300) && ($urandom_range(0, 3) != 0);
        if (n == 600) begin
          idle_on  = 1'b0;
          hold_req = 1'b1;
        end
      end
      send_item(trig_op_e'($urandom_range(0, 1)), next_random_angle());
    end
    in_valid_i <= 1'b0;

    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // sink side: random stalls, plus one long hold so the pipeline backs up
  initial begin
    out_ready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (idle_on && $urandom_range(0, 3) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end else begin
        out_ready_i <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  initial begin
    #5000000;
    $display("Verification failed");
    $finish;
  end

endmodule
